[src/crc8_framed_packet_decoder_unit_defines.svh]
// Assertion macros shared by the frame decoder RTL.
// Each macro wraps one clocked, reset-qualified concurrent assertion on clk and rst_n.
`ifndef CRC8_FRAMED_PACKET_DECODER_UNIT_DEFINES_SVH
`define CRC8_FRAMED_PACKET_DECODER_UNIT_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define CRC8FD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the following clock edge.
`define CRC8FD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/crc8fd_pkg.sv]
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// Has no dependencies; used by the frame tracker and the top level.
`timescale 1ns / 1ps

package crc8fd_pkg;

    localparam int PAYLOAD_LEN = 6;
    localparam int STORE_DEPTH = 6;
    localparam int COUNT_W     = $clog2(PAYLOAD_LEN + 1);
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 1'd1;

    typedef struct packed {
        logic [7:0]  sequence_number;
        logic [7:0]  mode_byte;
        logic [15:0] channel_one_width;
        logic [15:0] channel_two_width;
    } result_t;

    typedef struct packed {
        logic at_crc_byte;
        logic crc_match;
    } frame_status_t;

    // Bytewise CRC-8, MSB first, no reflection and no final xor.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[src/crc8fd_framer.sv]
// Frame tracker: header hunt, length check, payload capture and running CRC-8.
// Depends on crc8fd_pkg for sizes, the result type and the CRC update.
`timescale 1ns / 1ps

module crc8fd_framer
    import crc8fd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_take,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    header_first,
    input  logic [7:0]    header_second,
    output frame_status_t status,
    output result_t       frame_result
);

    typedef enum logic [1:0] {
        PH_HEAD0,
        PH_HEAD1,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         store_reg [STORE_DEPTH];
    logic               store_we;
    logic               body_data;

    assign body_data = (phase_reg == PH_BODY) && (count_reg < COUNT_W'(PAYLOAD_LEN));
    assign store_we  = byte_take && body_data && (count_reg < COUNT_W'(STORE_DEPTH));

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        case (phase_reg)
            PH_HEAD0:
            begin
                if (rx_byte == header_first)
                    phase_next = PH_HEAD1;
            end
            PH_HEAD1:
            begin
                if (rx_byte == header_second)
                    phase_next = PH_LEN;
                else if (rx_byte != header_first)
                    phase_next = PH_HEAD0;
            end
            PH_LEN:
            begin
                if (rx_byte == 8'(PAYLOAD_LEN))
                begin
                    crc_next   = crc8_feed(8'h00, rx_byte);
                    count_next = '0;
                    phase_next = PH_BODY;
                end
                else
                begin
                    phase_next = PH_HEAD0;
                end
            end
            PH_BODY:
            begin
                if (body_data)
                begin
                    crc_next   = crc8_feed(crc_reg, rx_byte);
                    count_next = count_reg + COUNT_W'(1);
                end
                else
                begin
                    phase_next = PH_HEAD0;
                    count_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_HEAD0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD0;
            count_reg <= '0;
            crc_reg   <= '0;
        end
        else if (byte_take)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[count_reg[STORE_IDX_W-1:0]] <= rx_byte;
    end

    assign status.at_crc_byte = (phase_reg == PH_BODY) && !body_data;
    assign status.crc_match   = (rx_byte == crc_reg);

    assign frame_result.sequence_number   = store_reg[0];
    assign frame_result.mode_byte         = store_reg[1];
    assign frame_result.channel_one_width = {store_reg[2], store_reg[3]};
    assign frame_result.channel_two_width = {store_reg[4], store_reg[5]};

endmodule

[src/crc8_framed_packet_decoder_unit.sv]
// This block takes one received byte per item, at up to one item per clock, and hunts for
// frames of two header bytes, a length byte equal to the fixed payload length, the payload
// and a CRC-8 (polynomial 0x07, initial value 0) over the length byte and payload. Each
// byte is handled by the frame tracker as it is taken, and a good frame's result appears
// in the output register in the cycle after its CRC byte is accepted; a frame with a bad CRC
// or wrong length produces nothing. The input stalls only when a CRC byte arrives while
// the previous result is still held by a stalled output.
// Depends on crc8fd_pkg, crc8fd_framer and the assertion macro header.
`timescale 1ns / 1ps
`include "crc8_framed_packet_decoder_unit_defines.svh"

module crc8_framed_packet_decoder_unit
    import crc8fd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            sequence_number,
    output logic [7:0]            mode_byte,
    output logic [15:0]           channel_one_width,
    output logic [15:0]           channel_two_width
);

    logic [7:0]    header_first_reg;
    logic [7:0]    header_second_reg;
    logic          out_valid_reg, out_valid_next;
    result_t       result_reg;
    frame_status_t status;
    result_t       frame_result;
    logic          in_take;
    logic          result_load;

    assign in_stall    = out_valid_reg && out_stall && status.at_crc_byte;
    assign in_take     = in_valid && !in_stall;
    assign result_load = in_take && status.at_crc_byte && status.crc_match;

    crc8fd_framer u_framer (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_take     (in_take),
        .rx_byte       (rx_byte),
        .header_first  (header_first_reg),
        .header_second (header_second_reg),
        .status        (status),
        .frame_result  (frame_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= 8'd170;
            header_second_reg <= 8'd85;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                REG_HEADER_SECOND: header_second_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
            result_reg <= frame_result;
    end

    assign out_valid         = out_valid_reg;
    assign sequence_number   = result_reg.sequence_number;
    assign mode_byte         = result_reg.mode_byte;
    assign channel_one_width = result_reg.channel_one_width;
    assign channel_two_width = result_reg.channel_two_width;

    `CRC8FD_ASSERT_NEXT(a_good_frame_loads, result_load, out_valid, "good frame did not load a result")
    `CRC8FD_ASSERT(a_no_overwrite, !(out_valid && out_stall && result_load), "held result overwritten")
    `CRC8FD_ASSERT_NEXT(a_rise_from_load, !out_valid && !result_load, !out_valid, "result without a frame")

endmodule
